// ===== rtl/pn3_pkg.sv =====
// ----------------------------------------------------------------------------
// pn3_pkg
// Shared types, constants and arithmetic helpers of the 3D gradient noise unit.
// ----------------------------------------------------------------------------
package pn3_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int INT_BITS   = 8;
	localparam int COORD_W    = FRAC_BITS + INT_BITS;
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int HASH_W     = 8;
	localparam int OUT_W      = 18;
	localparam int VAL_W      = 19;
	localparam int WT_W       = FRAC_BITS + 1;
	localparam int PROD_W     = VAL_W + WT_W + 1;

	localparam logic [19:0] FADE_C15 = 20'(15 * (1 << FRAC_BITS));
	localparam logic [19:0] FADE_C10 = 20'(10 * (1 << FRAC_BITS));
	localparam logic [2:0]  FADE_C6  = 3'd6;
	localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1 << (FRAC_BITS - 1));

	localparam logic signed [VAL_W-1:0] OUT_MAX = VAL_W'(131071);
	localparam logic signed [VAL_W-1:0] OUT_MIN = -VAL_W'(131072);

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

	typedef logic signed [VAL_W-1:0] val_t;

	// Signed product scaled down by 2^FRAC_BITS, rounded half away from zero.
	function automatic val_t rnd_shift(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] m;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		m   = (mag + PROD_W'(HALF)) >> FRAC_BITS;
		return v[PROD_W-1] ? -val_t'(m[VAL_W-1:0]) : val_t'(m[VAL_W-1:0]);
	endfunction

	// Dot product of the corner offset with one of the twelve gradients, picked by a four-bit hash.
	function automatic val_t grad_dot(input logic [3:0] h, input val_t dx,
			input val_t dy, input val_t dz);
		val_t r;
		unique case (h)
			4'd0:  r =  dx + dy;
			4'd1:  r = -dx + dy;
			4'd2:  r =  dx - dy;
			4'd3:  r = -dx - dy;
			4'd4:  r =  dx + dz;
			4'd5:  r = -dx + dz;
			4'd6:  r =  dx - dz;
			4'd7:  r = -dx - dz;
			4'd8:  r =  dy + dz;
			4'd9:  r = -dy + dz;
			4'd10: r =  dy - dz;
			4'd11: r = -dy - dz;
			4'd12: r =  dx + dy;
			4'd13: r = -dx + dy;
			4'd14: r = -dy + dz;
			4'd15: r = -dy - dz;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/pn3_ram.sv =====
// ----------------------------------------------------------------------------
// pn3_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pn3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/perlin_noise_3d.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_3d
// Improved 3D gradient noise on 8.16 fixed-point coordinates, with a loadable
// permutation table held in fourteen identical copies.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake       Payload
// request   in         start / busy    cmd, coord_x/y/z, table_index, table_value
// result    out        done strobe     noise_value
//
// One request is taken per cycle unless busy holds off a load; an evaluation
// gives its result on done after the three chained table reads, the corner
// gradients and the three lerps. A load gives no result and is held off in the
// cycle after an evaluation is accepted. Reset clears the valid bits only; the
// table holds no defined value until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
module perlin_noise_3d (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cmd,
	input  logic [pn3_pkg::COORD_W-1:0]         coord_x,
	input  logic [pn3_pkg::COORD_W-1:0]         coord_y,
	input  logic [pn3_pkg::COORD_W-1:0]         coord_z,
	input  logic [pn3_pkg::IDX_W-1:0]           table_index,
	input  logic [pn3_pkg::HASH_W-1:0]          table_value,
	output logic                                done,
	output logic signed [pn3_pkg::OUT_W-1:0]    noise_value
);

	localparam int F  = pn3_pkg::FRAC_BITS;
	localparam int IW = pn3_pkg::IDX_W;
	localparam int HW = pn3_pkg::HASH_W;
	localparam int VW = pn3_pkg::VAL_W;
	localparam int WW = pn3_pkg::WT_W;
	localparam int PW = pn3_pkg::PROD_W;

	logic accept, load_we, eval_in;
	logic [10:1] vld_q;

	logic [pn3_pkg::COORD_W-1:0] coord_in [3];
	assign coord_in[0] = coord_x;
	assign coord_in[1] = coord_y;
	assign coord_in[2] = coord_z;

	assign busy    = vld_q[1] && (cmd == pn3_pkg::CMD_LOAD);
	assign accept  = start && !busy;
	assign load_we = accept && (cmd == pn3_pkg::CMD_LOAD);
	assign eval_in = accept && (cmd == pn3_pkg::CMD_EVAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[9:1], eval_in};
		end
	end

	// Table lookups: two, four and eight reads, each level addressed by the registered result of the one before.
	logic [IW-1:0] addr1 [2];
	logic [IW-1:0] addr2 [4];
	logic [IW-1:0] addr3 [8];
	logic [HW-1:0] hx_s1 [2];
	logic [HW-1:0] hy_s2 [4];
	logic [HW-1:0] h_s3  [8];
	logic [IW-1:0] cy_s1, cz_s1, cz_s2;

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			addr1[j] = IW'(coord_x[F +: IW] + IW'(j));
		end
		for (int m = 0; m < 4; m++) begin
			addr2[m] = IW'(hx_s1[m % 2] + cy_s1 + IW'(m / 2));
		end
		for (int k = 0; k < 8; k++) begin
			addr3[k] = IW'(hy_s2[k % 4] + cz_s2 + IW'(k / 4));
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_l1
		pn3_ram #(.WIDTH(HW), .DEPTH(pn3_pkg::TABLE_SIZE)) u_ram (
			.clk(clk), .we(load_we), .waddr(table_index), .wdata(table_value),
			.raddr(addr1[g]), .rdata(hx_s1[g]));
	end
	for (genvar g = 0; g < 4; g++) begin : g_l2
		pn3_ram #(.WIDTH(HW), .DEPTH(pn3_pkg::TABLE_SIZE)) u_ram (
			.clk(clk), .we(load_we), .waddr(table_index), .wdata(table_value),
			.raddr(addr2[g]), .rdata(hy_s2[g]));
	end
	for (genvar g = 0; g < 8; g++) begin : g_l3
		pn3_ram #(.WIDTH(HW), .DEPTH(pn3_pkg::TABLE_SIZE)) u_ram (
			.clk(clk), .we(load_we), .waddr(table_index), .wdata(table_value),
			.raddr(addr3[g]), .rdata(h_s3[g]));
	end

	// Fade pipeline and fraction delay line.
	logic [F-1:0]    fr_s1 [3];
	logic [F-1:0]    fr_s2 [3];
	logic [F-1:0]    fr_s3 [3];
	logic [35:0]     fp_s1 [3];
	logic [31:0]     ff_s1 [3];
	logic [19:0]     r_s2  [3];
	logic [32:0]     cp_s2 [3];
	logic [36:0]     fd_s3 [3];
	logic [WW-1:0]   wt_s4 [3];

	always_ff @(posedge clk) begin
		cy_s1 <= coord_y[F +: IW];
		cz_s1 <= coord_z[F +: IW];
		cz_s2 <= cz_s1;
		for (int a = 0; a < 3; a++) begin
			logic [F-1:0]  f;
			logic [19:0]   p;
			logic [36:0]   fps;
			logic [32:0]   ffs;
			logic [33:0]   cps;
			logic [WW-1:0] f2;
			logic [WW-1:0] c;
			logic [37:0]   fds;
			f   = coord_in[a][F-1:0];
			p   = pn3_pkg::FADE_C15 - 20'(f) * 20'(pn3_pkg::FADE_C6);
			fr_s1[a] <= f;
			fp_s1[a] <= 36'(f) * 36'(p);
			ff_s1[a] <= 32'(f) * 32'(f);
			fps = 37'(fp_s1[a]) + 37'(pn3_pkg::HALF);
			ffs = 33'(ff_s1[a]) + 33'(pn3_pkg::HALF);
			f2  = WW'(ffs >> F);
			fr_s2[a] <= fr_s1[a];
			r_s2[a]  <= pn3_pkg::FADE_C10 - 20'(fps >> F);
			cp_s2[a] <= 33'(f2) * 33'(fr_s1[a]);
			cps = 34'(cp_s2[a]) + 34'(pn3_pkg::HALF);
			c   = WW'(cps >> F);
			fr_s3[a] <= fr_s2[a];
			fd_s3[a] <= 37'(c) * 37'(r_s2[a]);
			fds = 38'(fd_s3[a]) + 38'(pn3_pkg::HALF);
			wt_s4[a] <= WW'(fds >> F);
		end
	end

	// Corner gradients and trilinear blend.
	localparam logic signed [VW-1:0] ONE = VW'(1 << F);

	pn3_pkg::val_t n_s4 [8];
	pn3_pkg::val_t a_s5 [4];
	logic signed [PW-1:0] px_s5 [4];
	pn3_pkg::val_t x_s6 [4];
	pn3_pkg::val_t a_s7 [2];
	logic signed [PW-1:0] py_s7 [2];
	pn3_pkg::val_t y_s8 [2];
	pn3_pkg::val_t a_s9;
	logic signed [PW-1:0] pz_s9;
	logic [WW-1:0] wt1_s5, wt1_s6, wt2_s5, wt2_s6, wt2_s7, wt2_s8;

	always_ff @(posedge clk) begin
		pn3_pkg::val_t v;
		for (int k = 0; k < 8; k++) begin
			pn3_pkg::val_t dx, dy, dz;
			dx = pn3_pkg::val_t'({1'b0, fr_s3[0]}) - ((k & 1) != 0 ? ONE : '0);
			dy = pn3_pkg::val_t'({1'b0, fr_s3[1]}) - ((k & 2) != 0 ? ONE : '0);
			dz = pn3_pkg::val_t'({1'b0, fr_s3[2]}) - ((k & 4) != 0 ? ONE : '0);
			n_s4[k] <= pn3_pkg::grad_dot(h_s3[k][3:0], dx, dy, dz);
		end
		for (int i = 0; i < 4; i++) begin
			a_s5[i]  <= n_s4[2*i];
			px_s5[i] <= PW'(n_s4[2*i+1] - n_s4[2*i]) * PW'($signed({1'b0, wt_s4[0]}));
			x_s6[i]  <= a_s5[i] + pn3_pkg::rnd_shift(px_s5[i]);
		end
		wt1_s5 <= wt_s4[1];
		wt1_s6 <= wt1_s5;
		wt2_s5 <= wt_s4[2];
		wt2_s6 <= wt2_s5;
		wt2_s7 <= wt2_s6;
		wt2_s8 <= wt2_s7;
		for (int i = 0; i < 2; i++) begin
			a_s7[i]  <= x_s6[2*i];
			py_s7[i] <= PW'(x_s6[2*i+1] - x_s6[2*i]) * PW'($signed({1'b0, wt1_s6}));
			y_s8[i]  <= a_s7[i] + pn3_pkg::rnd_shift(py_s7[i]);
		end
		a_s9  <= y_s8[0];
		pz_s9 <= PW'(y_s8[1] - y_s8[0]) * PW'($signed({1'b0, wt2_s8}));
		v = a_s9 + pn3_pkg::rnd_shift(pz_s9);
		if (v > pn3_pkg::OUT_MAX) begin
			v = pn3_pkg::OUT_MAX;
		end else if (v < pn3_pkg::OUT_MIN) begin
			v = pn3_pkg::OUT_MIN;
		end
		noise_value <= v[pn3_pkg::OUT_W-1:0];
	end

	assign done = vld_q[10];

endmodule

// ===== sim/tb_perlin_noise_3d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perlin_noise_3d
// Self-checking testbench of the 3D gradient noise unit. It loads a shuffled
// permutation table and then runs directed corner points and random requests
// with random idle bursts. Every evaluation is predicted in a small scoreboard,
// and each done strobe is checked against the oldest expected noise value.
// ----------------------------------------------------------------------------
module tb_perlin_noise_3d;

	class noise_scoreboard;
		logic [7:0]         perm[256];
		logic signed [17:0] noise_q[$];
		int                 errors;
		int                 loads;
		int                 evals;

		function longint mul_round(longint a, longint b);
			return (a * b + 32768) >>> 16;
		endfunction

		function longint shift_round(longint v);
			longint m;
			m = (v < 0) ? -v : v;
			m = (m + 32768) >>> 16;
			return (v < 0) ? -m : m;
		endfunction

		function longint fade_of(longint f);
			longint p, r, c;
			p = 15 * 65536 - 6 * f;
			r = 10 * 65536 - mul_round(f, p);
			c = mul_round(mul_round(f, f), f);
			return mul_round(c, r);
		endfunction

		function longint blend(longint a, longint b, longint w);
			return a + shift_round((b - a) * w);
		endfunction

		function longint grad_dot_of(logic [3:0] h, longint dx, longint dy, longint dz);
			case (h)
				4'd0, 4'd12: return  dx + dy;
				4'd1, 4'd13: return -dx + dy;
				4'd2:        return  dx - dy;
				4'd3:        return -dx - dy;
				4'd4:        return  dx + dz;
				4'd5:        return -dx + dz;
				4'd6:        return  dx - dz;
				4'd7:        return -dx - dz;
				4'd8:        return  dy + dz;
				4'd9, 4'd14: return -dy + dz;
				4'd10:       return  dy - dz;
				default:     return -dy - dz;
			endcase
		endfunction

		function logic signed [17:0] noise_at(logic [23:0] x, logic [23:0] y,
				logic [23:0] z);
			logic [23:0] co[3];
			logic [7:0]  lat[3];
			logic [7:0]  hx, hy, h;
			longint      fr[3], wt[3], n[8], v;
			int          ox, oy, oz;
			co[0] = x;
			co[1] = y;
			co[2] = z;
			for (int k = 0; k < 3; k++) begin
				lat[k] = co[k][23:16];
				fr[k]  = co[k][15:0];
				wt[k]  = fade_of(fr[k]);
			end
			for (int k = 0; k < 8; k++) begin
				ox = k & 1;
				oy = (k >> 1) & 1;
				oz = (k >> 2) & 1;
				hx = perm[8'(lat[0] + ox)];
				hy = perm[8'(hx + lat[1] + oy)];
				h  = perm[8'(hy + lat[2] + oz)];
				n[k] = grad_dot_of(h[3:0], fr[0] - ox * 65536, fr[1] - oy * 65536,
					fr[2] - oz * 65536);
			end
			v = blend(blend(blend(n[0], n[1], wt[0]), blend(n[2], n[3], wt[0]), wt[1]),
				blend(blend(n[4], n[5], wt[0]), blend(n[6], n[7], wt[0]), wt[1]), wt[2]);
			if (v > 131071)
				v = 131071;
			if (v < -131072)
				v = -131072;
			return 18'(v);
		endfunction

		function void note_request(pn3_pkg::cmd_t c, logic [23:0] x, logic [23:0] y,
				logic [23:0] z, logic [7:0] idx, logic [7:0] val);
			if (c == pn3_pkg::CMD_LOAD) begin
				perm[idx] = val;
				loads++;
			end else begin
				noise_q.push_back(noise_at(x, y, z));
				evals++;
			end
		endfunction

		function void check_result(logic signed [17:0] v);
			logic signed [17:0] e;
			if (noise_q.size() == 0) begin
				$error("noise_value: unexpected result %0d", v);
				errors++;
				return;
			end
			e = noise_q.pop_front();
			if (v !== e) begin
				$error("noise_value: expected %0d, actual %0d", e, v);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               cmd;
	logic [23:0]        coord_x;
	logic [23:0]        coord_y;
	logic [23:0]        coord_z;
	logic [7:0]         table_index;
	logic [7:0]         table_value;
	logic               done;
	logic signed [17:0] noise_value;

	noise_scoreboard sb = new();

	perlin_noise_3d i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.table_index(table_index), .table_value(table_value),
		.done(done), .noise_value(noise_value)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_request(pn3_pkg::cmd_t'(cmd), coord_x, coord_y, coord_z,
				table_index, table_value);
		if (arst_n && done)
			sb.check_result(noise_value);
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [23:0] pick_coord();
		case ($urandom_range(0, 7))
			0:       return {$urandom_range(0, 255) == 0 ? 8'hFF : 8'($urandom), 16'h0000};
			1:       return {8'($urandom), 16'hFFFF};
			2:       return {8'($urandom), 16'h8000};
			3:       return {8'hFF, 16'($urandom)};
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_request(pn3_pkg::cmd_t c, logic [23:0] x, logic [23:0] y,
			logic [23:0] z, logic [7:0] idx, logic [7:0] val);
		start       <= 1'b1;
		cmd         <= c;
		coord_x     <= x;
		coord_y     <= y;
		coord_z     <= z;
		table_index <= idx;
		table_value <= val;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic maybe_idle(bit allowed);
		if (allowed && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.noise_q.size() != 0);
	endtask

	initial begin
		logic [7:0]  shuffle[256];
		logic [7:0]  tmp;
		logic [23:0] edges[6];
		int          j;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = pn3_pkg::CMD_LOAD;
		coord_x     = '0;
		coord_y     = '0;
		coord_z     = '0;
		table_index = '0;
		table_value = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 256; i++)
			shuffle[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j          = $urandom_range(0, i);
			tmp        = shuffle[i];
			shuffle[i] = shuffle[j];
			shuffle[j] = tmp;
		end
		for (int i = 0; i < 256; i++) begin
			send_request(pn3_pkg::CMD_LOAD, 24'($urandom), 24'($urandom), 24'($urandom),
				8'(i), shuffle[i]);
			maybe_idle(1'b1);
		end

		edges = '{24'h000000, 24'hFFFFFF, 24'h008000, 24'hFF0000, 24'h00FFFF, 24'h7F8001};
		for (int i = 0; i < 6; i++) begin
			send_request(pn3_pkg::CMD_EVAL, edges[i], edges[i], edges[i], 8'($urandom),
				8'($urandom));
			send_request(pn3_pkg::CMD_EVAL, edges[i], edges[(i + 1) % 6],
				edges[(i + 3) % 6], 8'hFF, 8'hFF);
		end
		send_request(pn3_pkg::CMD_EVAL, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 8'h00, 8'h00);
		send_request(pn3_pkg::CMD_LOAD, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'h00, 8'hFF);
		send_request(pn3_pkg::CMD_EVAL, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 8'h00, 8'h00);
		send_request(pn3_pkg::CMD_LOAD, 24'h000000, 24'h000000, 24'h000000, 8'hFF, 8'h00);
		send_request(pn3_pkg::CMD_EVAL, 24'hFF8000, 24'hFF8000, 24'hFF8000, 8'h00, 8'h00);
		drain();

		for (int i = 0; i < 430; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_request(pn3_pkg::CMD_LOAD, 24'($urandom), 24'($urandom),
					24'($urandom), 8'($urandom), 8'($urandom));
			else
				send_request(pn3_pkg::CMD_EVAL, pick_coord(), pick_coord(), pick_coord(),
					8'($urandom), 8'($urandom));
			if (i == 215)
				drain();
			else
				maybe_idle(i < 345);
		end

		drain();
		repeat (20) @(posedge clk);
		while (sb.noise_q.size() != 0) begin
			$error("noise_value: expected %0d, no result", sb.noise_q.pop_front());
			sb.errors++;
		end
		$display("Covered %0d table loads and %0d noise evaluations,", sb.loads, sb.evals);
		$display("including cell wrap, fraction edges and back-to-back requests.");
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== perlin_noise_3d.f =====
rtl/pn3_pkg.sv
rtl/pn3_ram.sv
rtl/perlin_noise_3d.sv
sim/tb_perlin_noise_3d.sv
